// ===== src/lglin_pkg.sv =====
// ----------------------------------------------------------------------------
// lglin_pkg: shared types and constants of the log-to-linear curve resampler
// Sequencer states, request and status codes, register indexes and the
// fixed widths of the configuration and status ports.
// ----------------------------------------------------------------------------
package lglin_pkg;

	// configuration port
	localparam int PC_W  = 9;
	localparam int ECF_W = 11;
	localparam int CFG_W = 11;

	localparam logic REG_POINT_COUNT = 1'b0;
	localparam logic REG_ENTRY_COUNT = 1'b1;

	localparam logic [PC_W-1:0]  POINT_COUNT_RST = 9'd2;
	localparam logic [ECF_W-1:0] ENTRY_COUNT_RST = 11'd1024;

	// request codes
	localparam logic OP_LOAD    = 1'b0;
	localparam logic OP_REQUEST = 1'b1;

	// result status codes
	localparam int STATUS_W = 2;
	localparam logic [STATUS_W-1:0] STATUS_OK         = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_NOT_LOADED = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_EMITTED    = 2'd2;

	// fixed-point log2: mantissa with 31 fraction bits, result with 24
	localparam int FRAC_W   = 24;
	localparam int M_FRAC   = 31;
	localparam int M_W      = 32;
	localparam int LG_CNT_W = 5;
	localparam logic [LG_CNT_W-1:0] LG_STEPS = 5'd24;

	// request sequencer
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_E0,
		ST_E1,
		ST_ADV_CHK,
		ST_L_LOGTOP,
		ST_L_MUL,
		ST_L_DIV,
		ST_L_SRCH,
		ST_L_LOGMID,
		ST_ADV_USE,
		ST_EVAL,
		ST_I_MUL,
		ST_I_DIV
	} state_t;

endpackage

// ===== src/log_to_linear_curve_resampler_top.sv =====
// ----------------------------------------------------------------------------
// log_to_linear_curve_resampler_top: log-axis curve to linear table
// Stores a curve sampled on a log axis in a RAM and emits the linear-axis
// table one entry per request, interpolating between landed points.
//
//  channel   | signals                                   | handshake
//  ----------+-------------------------------------------+---------------------
//  config    | cfg_write, cfg_index, cfg_data            | write when cfg_write
//  request   | start, busy, opcode, point_value          | start & !busy
//  result    | done, entry_index, entry_value,           | one-cycle strobe
//            | last_entry, status                        |
//
// a load is written while idle and leaves busy low; a rejected request gives its result in the next cycle
// entry 0 is read from the RAM and emitted from ST_E0; an entry inside the current segment is emitted from
// ST_EVAL, or from ST_I_DIV when it is interpolated through the serial divider
// opening a segment runs, for each point examined, the shared 24-step log2
// unit on the top index, the serial divider and a binary search for the
// landed index; the log2 unit and the binary search dominate
// reset clears all control state; the curve RAM holds garbage until loaded
// results cannot be stalled; busy is high while a request is in work
// ----------------------------------------------------------------------------
module log_to_linear_curve_resampler_top #(
	parameter int MAX_POINTS  = 256,
	parameter int MAX_ENTRIES = 1024,
	parameter int VALUE_WIDTH = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_write,
	input  logic                                 cfg_index,
	input  logic [lglin_pkg::CFG_W-1:0]          cfg_data,
	input  logic                                 start,
	output logic                                 busy,
	input  logic                                 opcode,
	input  logic signed [VALUE_WIDTH-1:0]        point_value,
	output logic                                 done,
	output logic [$clog2(MAX_ENTRIES)-1:0]       entry_index,
	output logic signed [VALUE_WIDTH-1:0]        entry_value,
	output logic                                 last_entry,
	output logic [lglin_pkg::STATUS_W-1:0]       status
);
	import lglin_pkg::*;

	localparam int VW    = VALUE_WIDTH;
	localparam int PAW   = $clog2(MAX_POINTS);
	localparam int CNT_W = $clog2(MAX_POINTS + 1);
	localparam int IW    = $clog2(MAX_ENTRIES);
	localparam int EC_W  = $clog2(MAX_ENTRIES + 1);
	localparam int KW    = $clog2(IW);
	localparam int RW    = KW + FRAC_W;
	localparam int NUMW  = CNT_W + RW;
	localparam int INW   = VW + IW + 1;
	localparam int DNW   = (NUMW > INW) ? NUMW : INW;
	localparam int DDW   = (CNT_W > IW) ? CNT_W : IW;
	localparam int DCW   = $clog2(DNW + 1);

	// configuration and run state
	logic [PC_W-1:0]  point_count_q;
	logic [ECF_W-1:0] entry_count_q;
	state_t           state_q, state_d;
	logic [CNT_W-1:0] points_loaded_q;
	logic [EC_W-1:0]  entry_counter_q;
	logic [CNT_W-1:0] seg_s_q;
	logic             adv_phase_q;
	logic [IW-1:0]    low_idx_q, high_idx_q;
	logic [VW-1:0]    low_val_q, high_val_q;
	logic [IW-1:0]    e_q;

	// curve memory
	logic [VW-1:0]    curve_mem [MAX_POINTS];
	logic [VW-1:0]    mem_rd_q;
	logic             mem_wr_en, mem_rd_en;
	logic [PAW-1:0]   mem_rd_addr;

	// log2 unit
	logic [M_W-1:0]      lg_m_q;
	logic [KW-1:0]       lg_k_q;
	logic [FRAC_W-1:0]   lg_frac_q;
	logic [LG_CNT_W-1:0] lg_cnt_q;
	logic                lg_start;
	logic [IW-1:0]       lg_n;
	logic [KW-1:0]       lg_k_new;
	logic [IW+M_FRAC-1:0] lg_wide;
	logic [2*M_W-1:0]    lg_sq;
	logic [M_W:0]        lg_sh;
	logic [RW-1:0]       lg_res;

	// serial divider
	logic [DDW-1:0] dv_rem_q, dv_den_q;
	logic [DNW-1:0] dv_quo_q;
	logic [DCW-1:0] dv_cnt_q;
	logic           dv_start;
	logic [DNW-1:0] dv_num;
	logic [DDW-1:0] dv_den;
	logic [DDW:0]   dv_trial, dv_diff;
	logic           dv_ge;

	// landing search and interpolation
	logic [NUMW-1:0]      prod_q;
	logic [RW-1:0]        t_q;
	logic [IW-1:0]        lo_q, hi_q, mid_q, mid;
	logic [IW:0]          span;
	logic signed [VW:0]   idiff;
	logic [IW-1:0]        idist;
	logic signed [INW:0]  iprod;
	logic [INW-1:0]       inum_q, imag;
	logic                 ineg_q;
	logic [VW-1:0]        iadj;

	// clamped registers
	logic [CNT_W-1:0] np_w, npm1_w;
	logic [EC_W-1:0]  ne_w, top_full;
	logic [IW-1:0]    top_w;
	logic             loaded, req_ok, new_seg, s_end;

	// result
	logic          emit;
	logic [VW-1:0] emit_val;

	// register clamping
	always_comb begin
		if (point_count_q < PC_W'(2)) begin
			np_w = CNT_W'(2);
		end else if (32'(point_count_q) > MAX_POINTS) begin
			np_w = CNT_W'(MAX_POINTS);
		end else begin
			np_w = CNT_W'(point_count_q);
		end
		if (entry_count_q < ECF_W'(3)) begin
			ne_w = EC_W'(3);
		end else if (32'(entry_count_q) > MAX_ENTRIES) begin
			ne_w = EC_W'(MAX_ENTRIES);
		end else begin
			ne_w = EC_W'(entry_count_q);
		end
	end

	assign npm1_w   = np_w - CNT_W'(1);
	assign top_full = ne_w - EC_W'(1);
	assign top_w    = top_full[IW-1:0];
	assign loaded   = !(points_loaded_q < np_w);
	assign req_ok   = loaded && (entry_counter_q < ne_w);
	assign new_seg  = entry_counter_q > EC_W'(high_idx_q);
	assign s_end    = !(seg_s_q < np_w);

	// log2 unit datapath
	always_comb begin
		lg_k_new = '0;
		for (int i = 0; i < IW; i++) begin
			if (lg_n[i]) lg_k_new = KW'(i);
		end
	end
	assign lg_wide = {lg_n, M_FRAC'(0)} >> lg_k_new;
	assign lg_sq   = lg_m_q * lg_m_q;
	assign lg_sh   = lg_sq[2*M_W-1:M_FRAC];
	assign lg_res  = {lg_k_q, lg_frac_q};

	// divider step
	assign dv_trial = {dv_rem_q, dv_quo_q[DNW-1]};
	assign dv_ge    = dv_trial >= {1'b0, dv_den_q};
	assign dv_diff  = dv_trial - {1'b0, dv_den_q};

	// search midpoint and interpolation terms
	assign span  = {1'b0, hi_q} - {1'b0, lo_q} + (IW+1)'(1);
	assign mid   = lo_q + span[IW:1];
	assign idiff = $signed({high_val_q[VW-1], high_val_q}) - $signed({low_val_q[VW-1], low_val_q});
	assign idist = e_q - low_idx_q;
	assign iprod = idiff * $signed({1'b0, idist});
	assign imag  = inum_q[INW-1] ? (-inum_q) : inum_q;
	assign iadj  = ineg_q ? (-dv_quo_q[VW-1:0]) : dv_quo_q[VW-1:0];

	assign mem_wr_en = (state_q == ST_IDLE) && start && (opcode == OP_LOAD) && !loaded;

	// next state
	always_comb begin : fsm_next
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start && opcode == OP_REQUEST && req_ok) begin
					if (entry_counter_q == EC_W'(0))      state_d = ST_E0;
					else if (entry_counter_q == EC_W'(1)) state_d = ST_E1;
					else if (new_seg)                     state_d = ST_ADV_CHK;
					else                                  state_d = ST_EVAL;
				end
			end
			ST_E0:       state_d = ST_IDLE;
			ST_E1:       state_d = ST_ADV_CHK;
			ST_ADV_CHK:  state_d = s_end ? ST_EVAL : ST_L_LOGTOP;
			ST_L_LOGTOP: if (lg_cnt_q == '0) state_d = ST_L_MUL;
			ST_L_MUL:    state_d = ST_L_DIV;
			ST_L_DIV:    if (dv_cnt_q == '0) state_d = ST_L_SRCH;
			ST_L_SRCH:   state_d = (lo_q < hi_q) ? ST_L_LOGMID : ST_ADV_USE;
			ST_L_LOGMID: if (lg_cnt_q == '0) state_d = ST_L_SRCH;
			ST_ADV_USE: begin
				if (adv_phase_q && lo_q != high_idx_q) state_d = ST_EVAL;
				else                                   state_d = ST_ADV_CHK;
			end
			ST_EVAL: begin
				if (e_q == low_idx_q || !(e_q < high_idx_q)) state_d = ST_IDLE;
				else                                          state_d = ST_I_MUL;
			end
			ST_I_MUL:    state_d = ST_I_DIV;
			ST_I_DIV:    if (dv_cnt_q == '0) state_d = ST_IDLE;
			default:     state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin : fsm_out
		mem_rd_en   = 1'b0;
		mem_rd_addr = seg_s_q[PAW-1:0];
		lg_start    = 1'b0;
		lg_n        = top_w;
		dv_start    = 1'b0;
		dv_num      = DNW'(prod_q);
		dv_den      = DDW'(npm1_w);
		emit        = 1'b0;
		emit_val    = mem_rd_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start && opcode == OP_REQUEST && req_ok && entry_counter_q < EC_W'(2)) begin
					mem_rd_en   = 1'b1;
					mem_rd_addr = '0;
				end
			end
			ST_E0: emit = 1'b1;
			ST_ADV_CHK: begin
				if (!s_end) begin
					mem_rd_en = 1'b1;
					lg_start  = 1'b1;
				end
			end
			ST_L_MUL: dv_start = 1'b1;
			ST_L_SRCH: begin
				if (lo_q < hi_q) begin
					lg_start = 1'b1;
					lg_n     = mid;
				end
			end
			ST_EVAL: begin
				if (e_q == low_idx_q) begin
					emit     = 1'b1;
					emit_val = low_val_q;
				end else if (!(e_q < high_idx_q)) begin
					emit     = 1'b1;
					emit_val = high_val_q;
				end
			end
			ST_I_MUL: begin
				dv_start = 1'b1;
				dv_num   = DNW'(imag);
				dv_den   = DDW'(high_idx_q - low_idx_q);
			end
			ST_I_DIV: begin
				if (dv_cnt_q == '0) begin
					emit     = 1'b1;
					emit_val = low_val_q + iadj;
				end
			end
			default: ;
		endcase
	end

	// curve ram
	always_ff @(posedge clk) begin : curve_ram
		if (mem_wr_en) curve_mem[points_loaded_q[PAW-1:0]] <= point_value;
		if (mem_rd_en) mem_rd_q <= curve_mem[mem_rd_addr];
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			point_count_q   <= POINT_COUNT_RST;
			entry_count_q   <= ENTRY_COUNT_RST;
			points_loaded_q <= '0;
			entry_counter_q <= '0;
			seg_s_q         <= '0;
			adv_phase_q     <= 1'b0;
			low_idx_q       <= '0;
			high_idx_q      <= '0;
			lg_cnt_q        <= '0;
			dv_cnt_q        <= '0;
			done            <= 1'b0;
		end else begin
			state_q <= state_d;
			// a result strobe for an emitted entry or a rejected request
			done    <= emit || ((state_q == ST_IDLE) && start && opcode == OP_REQUEST
				&& !req_ok);
			// log2 and divider step counters
			if (lg_start)              lg_cnt_q <= LG_STEPS;
			else if (lg_cnt_q != '0)   lg_cnt_q <= lg_cnt_q - LG_CNT_W'(1);
			if (dv_start)              dv_cnt_q <= DCW'(DNW);
			else if (dv_cnt_q != '0)   dv_cnt_q <= dv_cnt_q - DCW'(1);
			// a register write restarts the run
			if (cfg_write) begin
				unique case (cfg_index)
					REG_POINT_COUNT: point_count_q <= cfg_data[PC_W-1:0];
					REG_ENTRY_COUNT: entry_count_q <= cfg_data[ECF_W-1:0];
				endcase
				points_loaded_q <= '0;
				entry_counter_q <= '0;
				seg_s_q         <= '0;
				adv_phase_q     <= 1'b0;
				low_idx_q       <= '0;
				high_idx_q      <= '0;
			end else begin
				case (state_q)
					ST_IDLE: begin
						if (start && opcode == OP_LOAD && !loaded) begin
							points_loaded_q <= points_loaded_q + CNT_W'(1);
						end
						if (start && opcode == OP_REQUEST && req_ok
							&& entry_counter_q > EC_W'(1) && new_seg) begin
							low_idx_q   <= high_idx_q;
							adv_phase_q <= 1'b0;
						end
					end
					ST_E1: begin
						low_idx_q   <= IW'(1);
						seg_s_q     <= CNT_W'(1);
						adv_phase_q <= 1'b0;
					end
					ST_ADV_CHK: begin
						if (s_end && !adv_phase_q) high_idx_q <= low_idx_q;
					end
					ST_ADV_USE: begin
						if (!adv_phase_q) begin
							seg_s_q <= seg_s_q + CNT_W'(1);
							if (lo_q > low_idx_q) begin
								high_idx_q  <= lo_q;
								adv_phase_q <= 1'b1;
							end
						end else if (lo_q == high_idx_q) begin
							seg_s_q <= seg_s_q + CNT_W'(1);
						end
					end
					default: ;
				endcase
				if (emit) entry_counter_q <= entry_counter_q + EC_W'(1);
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				e_q <= entry_counter_q[IW-1:0];
				if (start && opcode == OP_REQUEST && req_ok && entry_counter_q > EC_W'(1)
					&& new_seg) begin
					low_val_q <= high_val_q;
				end
				if (start && opcode == OP_REQUEST && !req_ok) begin
					entry_index <= '0;
					entry_value <= '0;
					last_entry  <= 1'b0;
					status      <= loaded ? STATUS_EMITTED : STATUS_NOT_LOADED;
				end
			end
			ST_E1: low_val_q <= mem_rd_q;
			ST_ADV_CHK: begin
				if (s_end && !adv_phase_q) high_val_q <= low_val_q;
			end
			ST_L_LOGTOP: begin
				if (lg_cnt_q == '0) prod_q <= NUMW'(seg_s_q) * NUMW'(lg_res);
			end
			ST_L_DIV: begin
				if (dv_cnt_q == '0) begin
					t_q  <= dv_quo_q[RW-1:0];
					lo_q <= IW'(1);
					hi_q <= top_w;
				end
			end
			ST_L_SRCH: mid_q <= mid;
			ST_L_LOGMID: begin
				if (lg_cnt_q == '0) begin
					if (lg_res <= t_q) lo_q <= mid_q;
					else               hi_q <= mid_q - IW'(1);
				end
			end
			ST_ADV_USE: begin
				if (!adv_phase_q) begin
					if (lo_q > low_idx_q) high_val_q <= mem_rd_q;
					else                  low_val_q  <= mem_rd_q;
				end else if (lo_q == high_idx_q) begin
					high_val_q <= mem_rd_q;
				end
			end
			ST_EVAL:  inum_q <= iprod[INW-1:0];
			ST_I_MUL: ineg_q <= inum_q[INW-1];
			default: ;
		endcase
		// result register
		if (emit) begin
			entry_index <= e_q;
			entry_value <= emit_val;
			last_entry  <= (e_q == top_w);
			status      <= STATUS_OK;
		end
		// log2: square, renormalise, shift in one fraction bit per cycle
		if (lg_start) begin
			lg_m_q    <= lg_wide[M_W-1:0];
			lg_k_q    <= lg_k_new;
			lg_frac_q <= '0;
		end else if (lg_cnt_q != '0) begin
			if (lg_sh[M_W]) begin
				lg_m_q    <= lg_sh[M_W:1];
				lg_frac_q <= {lg_frac_q[FRAC_W-2:0], 1'b1};
			end else begin
				lg_m_q    <= lg_sh[M_W-1:0];
				lg_frac_q <= {lg_frac_q[FRAC_W-2:0], 1'b0};
			end
		end
		// restoring divider, one quotient bit per cycle
		if (dv_start) begin
			dv_quo_q <= dv_num;
			dv_rem_q <= '0;
			dv_den_q <= dv_den;
		end else if (dv_cnt_q != '0) begin
			dv_rem_q <= dv_ge ? dv_diff[DDW-1:0] : dv_trial[DDW-1:0];
			dv_quo_q <= {dv_quo_q[DNW-2:0], dv_ge};
		end
	end

	assign busy = (state_q != ST_IDLE);

	// checks
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != STATUS_OK) |-> (entry_index == '0 && entry_value == '0 && !last_entry))
		else $error("rejected request carries payload");
	a_loaded_bound: assert property (@(posedge clk) disable iff (!arst_n)
		points_loaded_q <= np_w)
		else $error("point count overrun");
	a_seg_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EVAL) |-> (low_idx_q <= high_idx_q && e_q >= low_idx_q))
		else $error("segment bounds out of order");
	a_done_src: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy || start))
		else $error("result without request");
	a_lg_free: assert property (@(posedge clk) disable iff (!arst_n)
		lg_start |-> (lg_cnt_q == '0))
		else $error("log2 unit restarted while running");

endmodule

// ===== tb/tb_log_to_linear_curve_resampler_top.sv =====
// ----------------------------------------------------------------------------
// tb_log_to_linear_curve_resampler_top: self-checking bench of the resampler
// Loads curves and requests table entries under several register settings,
// first from a short table of directed requests, then in random phases. Each
// result is compared with a behavioural predictor of the landing, segment and
// interpolation logic, or with a value typed into the table.
// ----------------------------------------------------------------------------
module tb_log_to_linear_curve_resampler_top;
	timeunit 1ns;
	timeprecision 1ps;

	import lglin_pkg::*;

	localparam int NPTS       = 256;
	localparam int NENT       = 1024;
	localparam int VW         = 16;
	localparam int ITEM_GOAL  = 1650;
	localparam longint LIMIT  = 4000000;

	typedef struct packed {
		logic [9:0]           idx;
		logic signed [VW-1:0] value;
		logic                 last;
		logic [STATUS_W-1:0]  stat;
	} entry_t;

	typedef struct {
		bit                   is_cfg;
		logic                 reg_idx;
		logic [CFG_W-1:0]     data;
		logic                 op;
		logic signed [VW-1:0] val;
		bit                   typed;
		entry_t               res;
	} row_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_write = 1'b0;
	logic                 cfg_index = 1'b0;
	logic [CFG_W-1:0]     cfg_data = '0;
	logic                 start = 1'b0;
	logic                 busy;
	logic                 opcode = OP_LOAD;
	logic signed [VW-1:0] point_value = '0;
	logic                 done;
	logic [9:0]           entry_index;
	logic signed [VW-1:0] entry_value;
	logic                 last_entry;
	logic [STATUS_W-1:0]  status;

	// predictor copy of registers and run state
	logic [PC_W-1:0]      pc_reg = POINT_COUNT_RST;
	logic [ECF_W-1:0]     ec_reg = ENTRY_COUNT_RST;
	int                   curve [NPTS];
	int                   n_loaded, n_emitted, seg_num, lo_idx, hi_idx, lo_val, hi_val;

	entry_t               pending_entries [$];
	row_t                 dir_tab [$];
	int                   fails = 0;
	int                   sent = 0;
	int                   idle_pct = 0;
	longint               cycles = 0;

	log_to_linear_curve_resampler_top #(
		.MAX_POINTS(NPTS), .MAX_ENTRIES(NENT), .VALUE_WIDTH(VW)
	) dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.start(start), .busy(busy), .opcode(opcode), .point_value(point_value),
		.done(done), .entry_index(entry_index), .entry_value(entry_value),
		.last_entry(last_entry), .status(status)
	);

	always #4 clk = ~clk;

	// timeout
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("[log_to_linear_curve_resampler_top] ERROR");
			$finish;
		end
	end

	function automatic int num_points();
		return (pc_reg < 2) ? 2 : ((pc_reg > NPTS) ? NPTS : int'(pc_reg));
	endfunction

	function automatic int num_entries();
		return (ec_reg < 3) ? 3 : ((ec_reg > NENT) ? NENT : int'(ec_reg));
	endfunction

	// log2 with 24 fraction bits by repeated squaring
	function automatic longint unsigned log2_q24(int unsigned n);
		longint unsigned m, r;
		int k;
		k = 0;
		while ((n >> k) > 1) k++;
		m = (longint'(n) << 31) >> k;
		r = longint'(k) << 24;
		for (int i = 23; i >= 0; i--) begin
			m = (m * m) >> 31;
			if (m >= 64'h1_0000_0000) begin
				m = m >> 1;
				r = r | (64'd1 << i);
			end
		end
		return r;
	endfunction

	// table index where point p lands
	function automatic int landed_index(int p);
		longint unsigned t;
		int lo, hi, mid;
		hi = num_entries() - 1;
		t = (longint'(p) * log2_q24(hi)) / longint'(num_points() - 1);
		lo = 1;
		while (lo < hi) begin
			mid = lo + (hi - lo + 1) / 2;
			if (log2_q24(mid) <= t) lo = mid;
			else hi = mid - 1;
		end
		return lo;
	endfunction

	// absorb points on the low index, then find the next segment end
	function automatic void next_segment();
		int s, b, np;
		np = num_points();
		s = seg_num;
		while (s < np && landed_index(s) <= lo_idx) begin
			lo_val = curve[s];
			s++;
		end
		if (s >= np) begin
			hi_idx = lo_idx;
			hi_val = lo_val;
			seg_num = s;
			return;
		end
		b = landed_index(s);
		hi_idx = b;
		hi_val = curve[s];
		s++;
		while (s < np && landed_index(s) == b) begin
			hi_val = curve[s];
			s++;
		end
		seg_num = s;
	endfunction

	function automatic void clear_run();
		n_loaded = 0; n_emitted = 0; seg_num = 0;
		lo_idx = 0; hi_idx = 0; lo_val = 0; hi_val = 0;
	endfunction

	// advance the predictor by one request; returns 1 when a result is due
	function automatic bit predict_entry(logic op, logic signed [VW-1:0] val,
			output entry_t res);
		int e, v;
		longint num;
		res = '0;
		if (op == OP_LOAD) begin
			if (n_loaded < num_points()) begin
				curve[n_loaded] = val;
				n_loaded++;
			end
			return 0;
		end
		if (n_loaded < num_points()) begin
			res.stat = STATUS_NOT_LOADED;
			return 1;
		end
		if (n_emitted >= num_entries()) begin
			res.stat = STATUS_EMITTED;
			return 1;
		end
		e = n_emitted;
		if (e == 0) v = curve[0];
		else begin
			if (e == 1) begin
				lo_idx = 1; lo_val = curve[0]; seg_num = 1;
				next_segment();
			end else if (e > hi_idx) begin
				lo_idx = hi_idx; lo_val = hi_val;
				next_segment();
			end
			if (e == lo_idx) v = lo_val;
			else if (e >= hi_idx) v = hi_val;
			else begin
				num = longint'(hi_val - lo_val) * longint'(e - lo_idx);
				v = lo_val + int'(num / longint'(hi_idx - lo_idx));
			end
		end
		n_emitted++;
		res.idx = e[9:0];
		res.value = v[VW-1:0];
		res.last = (e == num_entries() - 1);
		res.stat = STATUS_OK;
		return 1;
	endfunction

	task automatic report_mismatch(string field, longint got, longint want);
		fails++;
		$display("mismatch at %0t: %s got %0d expected %0d", $realtime, field, got, want);
	endtask

	// result checker
	always @(posedge clk) begin
		entry_t want;
		if (arst_n && done) begin
			if (pending_entries.size() == 0) begin
				report_mismatch("done", 1, 0);
			end else begin
				want = pending_entries.pop_front();
				if (entry_index !== want.idx) report_mismatch("entry_index", entry_index, want.idx);
				if (entry_value !== want.value)
					report_mismatch("entry_value", entry_value, want.value);
				if (last_entry !== want.last) report_mismatch("last_entry", last_entry, want.last);
				if (status !== want.stat) report_mismatch("status", status, want.stat);
			end
		end
	end

	// one request: hold start until taken, then predict
	task automatic send_request(logic op, logic signed [VW-1:0] val, bit typed, entry_t tres);
		entry_t res;
		bit due;
		@(negedge clk);
		start = 1'b1;
		opcode = op;
		point_value = val;
		do @(posedge clk); while (busy);
		due = predict_entry(op, val, res);
		if (due) pending_entries.push_back(typed ? tres : res);
		sent++;
		while ($urandom_range(99) < idle_pct) begin
			@(negedge clk);
			start = 1'b0;
		end
	endtask

	// let every expected result arrive and the block fall idle
	task automatic drain();
		@(negedge clk);
		start = 1'b0;
		do @(posedge clk); while (pending_entries.size() != 0 || busy);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [CFG_W-1:0] data);
		drain();
		@(negedge clk);
		cfg_write = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		if (idx == REG_POINT_COUNT) pc_reg = data[PC_W-1:0];
		else ec_reg = data[ECF_W-1:0];
		clear_run();
		@(negedge clk);
		cfg_write = 1'b0;
	endtask

	function automatic void add_cfg(logic idx, logic [CFG_W-1:0] data);
		row_t r;
		r = '{default: '0};
		r.is_cfg = 1; r.reg_idx = idx; r.data = data;
		dir_tab.push_back(r);
	endfunction

	function automatic void add_row(logic op, logic signed [VW-1:0] val, bit typed,
			entry_t res);
		row_t r;
		r = '{default: '0};
		r.op = op; r.val = val; r.typed = typed; r.res = res;
		dir_tab.push_back(r);
	endfunction

	function automatic logic signed [VW-1:0] rand_value();
		case ($urandom_range(7))
			0: return 16'sh7FFF;
			1: return 16'sh8000;
			default: return VW'($urandom);
		endcase
	endfunction

	// well-formed pass: early requests, curve, whole table, stray requests
	task automatic run_table(bit overload);
		entry_t none;
		none = '0;
		repeat ($urandom_range(2)) send_request(OP_REQUEST, 0, 0, none);
		repeat (num_points()) send_request(OP_LOAD, rand_value(), 0, none);
		if (overload) repeat ($urandom_range(1, 3)) send_request(OP_LOAD, rand_value(), 0, none);
		repeat (num_entries() + $urandom_range(2)) send_request(OP_REQUEST, 0, 0, none);
	endtask

	initial begin
		entry_t none;
		int np, ne, ph;
		logic [CFG_W-1:0] wp, we;
		none = '0;
		clear_run();
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: clamped registers, extremes, early and late requests
		add_row(OP_REQUEST, 0, 1, '{0, 0, 0, STATUS_NOT_LOADED});
		add_cfg(REG_POINT_COUNT, 11'd0);
		add_cfg(REG_ENTRY_COUNT, 11'd2);
		add_row(OP_LOAD, 16'sh8000, 0, none);
		add_row(OP_REQUEST, 0, 1, '{0, 0, 0, STATUS_NOT_LOADED});
		add_row(OP_LOAD, 16'sh7FFF, 0, none);
		add_row(OP_LOAD, 16'sh1234, 0, none);
		add_row(OP_REQUEST, 0, 1, '{10'd0, 16'sh8000, 1'b0, STATUS_OK});
		add_row(OP_REQUEST, 0, 1, '{10'd1, 16'sh8000, 1'b0, STATUS_OK});
		add_row(OP_REQUEST, 0, 1, '{10'd2, 16'sh7FFF, 1'b1, STATUS_OK});
		add_row(OP_REQUEST, 0, 1, '{0, 0, 0, STATUS_EMITTED});
		add_cfg(REG_ENTRY_COUNT, 11'h7FF);
		add_cfg(REG_POINT_COUNT, 11'h1FF);
		add_row(OP_LOAD, 16'sh0001, 0, none);
		add_row(OP_REQUEST, 0, 1, '{0, 0, 0, STATUS_NOT_LOADED});
		add_cfg(REG_POINT_COUNT, 11'd4);
		add_cfg(REG_ENTRY_COUNT, 11'd9);
		add_row(OP_LOAD, 16'sh0000, 0, none);
		add_row(OP_LOAD, -16'sd1, 0, none);
		add_row(OP_LOAD, 16'sd100, 0, none);
		add_row(OP_LOAD, -16'sd100, 0, none);
		for (int i = 0; i < 5; i++) add_row(OP_REQUEST, 0, 0, none);

		foreach (dir_tab[i]) begin
			if (dir_tab[i].is_cfg) write_reg(dir_tab[i].reg_idx, dir_tab[i].data);
			else send_request(dir_tab[i].op, dir_tab[i].val, dir_tab[i].typed,
					dir_tab[i].res);
		end

		// random phases under changing idle pressure
		ph = 0;
		while (sent < ITEM_GOAL) begin
			case (ph % 4)
				1: idle_pct = 84;
				3: idle_pct = 17;
				default: idle_pct = 0;
			endcase
			if (ph == 2) begin
				np = NPTS; ne = NENT;
			end else if ($urandom_range(9) == 0) begin
				np = $urandom_range(2, 40); ne = $urandom_range(100, 300);
			end else begin
				np = $urandom_range(2, 12); ne = $urandom_range(3, 60);
			end
			wp = CFG_W'(np);
			we = CFG_W'(ne);
			// out-of-range settings that clamp to the same values
			if (np == 2 && $urandom_range(1)) wp = CFG_W'($urandom_range(1));
			if (ne == 3 && $urandom_range(1)) we = CFG_W'($urandom_range(2));
			if (ph == 2) begin
				wp = 11'h1FF; we = 11'h7FF;
			end
			if ($urandom_range(1)) begin
				write_reg(REG_POINT_COUNT, wp);
				write_reg(REG_ENTRY_COUNT, we);
			end else begin
				write_reg(REG_ENTRY_COUNT, we);
				write_reg(REG_POINT_COUNT, wp);
			end
			if ($urandom_range(99) < 85) run_table($urandom_range(3) == 0);
			else repeat ($urandom_range(5, 30))
				send_request(1'($urandom_range(1)), rand_value(), 0, none);
			ph++;
		end

		drain();
		if (fails == 0) begin
			$display("[log_to_linear_curve_resampler_top] OK");
		end else begin
			$display("[log_to_linear_curve_resampler_top] ERROR");
		end
		$finish;
	end

endmodule
